// File: rtl/core/htc_pkg.sv
// htc_pkg: shared types and constants of the request target checker.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package htc_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] FORM_PATH      = 2'd0;
	localparam logic [1:0] FORM_ABSOLUTE  = 2'd1;
	localparam logic [1:0] FORM_AUTHORITY = 2'd2;

	typedef struct packed {
		logic [7:0] url_byte;
		logic       no_byte;
		logic       connect_mode;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic       url_ok;
		logic [1:0] url_form;
	} out_item_t;

	// byte classes, computed once in the front
	typedef struct packed {
		logic slash;
		logic star;
		logic colon;
		logic qmark;
		logic at;
		logic alpha;
		logic scheme_tail;
		logic pq;
		logic host;
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic no_byte;
		logic connect_mode;
		logic last;
	} entry_t;

endpackage

`default_nettype wire

// File: rtl/core/htc_front.sv
// htc_front: classifies each incoming target byte into flag bits.
// Depends on htc_pkg.
`default_nettype none

module htc_front
	import htc_pkg::*;
(
	input  wire in_item_t item,
	output entry_t       entry
);

	logic [7:0] c;
	logic       is_alpha;
	logic       is_digit;
	logic       host_punct;

	assign c        = item.url_byte;
	assign is_alpha = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);

	always_comb begin
		unique case (c)
			8'h21, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c,
			8'h2d, 8'h2e, 8'h3a, 8'h3b, 8'h3d, 8'h40, 8'h5b, 8'h5d, 8'h5f, 8'h7e:
				host_punct = 1'b1;
			default:
				host_punct = 1'b0;
		endcase
	end

	always_comb begin
		entry.cls.slash       = (c == 8'h2f);
		entry.cls.star        = (c == 8'h2a);
		entry.cls.colon       = (c == 8'h3a);
		entry.cls.qmark       = (c == 8'h3f);
		entry.cls.at          = (c == 8'h40);
		entry.cls.alpha       = is_alpha;
		entry.cls.scheme_tail = is_alpha || is_digit || c == 8'h2b || c == 8'h2d || c == 8'h2e;
		entry.cls.pq          = (c == 8'd9) || (c == 8'd12) || (c >= 8'd33 && c <= 8'd126);
		entry.cls.host        = is_alpha || is_digit || host_punct;
		entry.no_byte         = item.no_byte;
		entry.connect_mode    = item.connect_mode;
		entry.last            = item.last;
	end

endmodule

`default_nettype wire

// File: rtl/core/htc_queue.sv
// htc_queue: short flop queue of classified entries between front and back.
// Depends on htc_pkg.
`default_nettype none

module htc_queue
	import htc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         wr_en,
	input  wire entry_t wr_data,
	output logic        q_full,
	input  wire         rd_en,
	output logic        q_valid,
	output entry_t      rd_data
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign q_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/htc_back.sv
// htc_back: target phase machine and result register.
// Depends on htc_pkg; consumes entries from htc_queue.
`default_nettype none

module htc_back
	import htc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         q_valid,
	input  wire entry_t q_entry,
	output logic        q_pop,
	input  wire         pop,
	output logic        empty,
	output out_item_t   result
);

	typedef enum logic [2:0] {
		PH_START,
		PH_PATHQ,
		PH_SCHEME,
		PH_COLON,
		PH_SLASH,
		PH_HOST
	} phase_t;

	phase_t     phase_q, phase_n, h_phase;
	logic       prev_at_q, prev_n, h_prev;
	logic [1:0] form_q, form_n;
	logic       failed_q, fail_n, h_fail;
	logic       ok_n;
	logic       res_valid_q;
	out_item_t  res_q;
	cls_t       c;

	assign c      = q_entry.cls;
	assign empty  = !res_valid_q;
	assign result = res_q;
	assign q_pop  = q_valid && (!q_entry.last || !res_valid_q || pop);

	// host byte handling
	always_comb begin
		h_phase = PH_HOST;
		h_prev  = prev_at_q;
		h_fail  = 1'b0;
		if (c.slash || c.qmark) begin
			h_phase = PH_PATHQ;
			h_prev  = 1'b0;
		end else if (!c.host || (c.at && prev_at_q)) begin
			h_fail = 1'b1;
		end else begin
			h_prev = c.at;
		end
	end

	always_comb begin
		phase_n = phase_q;
		prev_n  = prev_at_q;
		form_n  = form_q;
		fail_n  = failed_q;
		if (!q_entry.no_byte && !failed_q) begin
			unique case (phase_q)
				PH_START: begin
					if (c.slash || c.star) begin
						form_n  = FORM_PATH;
						phase_n = PH_PATHQ;
					end else if (q_entry.connect_mode) begin
						form_n  = FORM_AUTHORITY;
						phase_n = h_phase;
						prev_n  = h_prev;
						fail_n  = h_fail;
					end else begin
						form_n  = FORM_ABSOLUTE;
						phase_n = PH_SCHEME;
						fail_n  = !c.alpha;
					end
				end
				PH_PATHQ: begin
					fail_n = !c.pq;
				end
				PH_SCHEME: begin
					if (c.colon) begin
						phase_n = PH_COLON;
					end else begin
						fail_n = !c.scheme_tail;
					end
				end
				PH_COLON: begin
					if (c.slash) begin
						phase_n = PH_SLASH;
					end else begin
						fail_n = 1'b1;
					end
				end
				PH_SLASH: begin
					if (c.slash) begin
						phase_n = PH_HOST;
						prev_n  = 1'b0;
					end else begin
						fail_n = 1'b1;
					end
				end
				PH_HOST: begin
					phase_n = h_phase;
					prev_n  = h_prev;
					fail_n  = h_fail;
				end
				default: begin
					fail_n = 1'b1;
				end
			endcase
		end
		ok_n = !fail_n && (phase_n == PH_PATHQ || phase_n == PH_HOST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			prev_at_q   <= 1'b0;
			form_q      <= FORM_PATH;
			failed_q    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (q_pop && q_entry.last) begin
				res_valid_q     <= 1'b1;
				res_q.url_ok    <= ok_n;
				res_q.url_form  <= form_n;
				phase_q         <= PH_START;
				prev_at_q       <= 1'b0;
				form_q          <= FORM_PATH;
				failed_q        <= 1'b0;
			end else begin
				if (pop) begin
					res_valid_q <= 1'b0;
				end
				if (q_pop) begin
					phase_q   <= phase_n;
					prev_at_q <= prev_n;
					form_q    <= form_n;
					failed_q  <= fail_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/http_request_target_checker.sv
// http_request_target_checker: top level; front classifier, entry queue, back phase machine.
// Depends on htc_pkg, htc_front, htc_queue, htc_back.
//
//   channel   | handshake         | payload
//   ----------+-------------------+--------------------------------------------
//   input     | push / full       | item   (url_byte, no_byte, connect_mode, last)
//   result    | pop / empty       | result (url_ok, url_form), one per last item
//
// One item per cycle while full is low; the phase machine updates once per entry.
// A last item is registered into the queue first, and its result then into
// the result register.
// Reset clears the queue and the result register at once; no clearing pass.
// A held result stalls the back only on the next last entry; the four-entry
// queue absorbs that, and full rises once it holds four entries.
`default_nettype none

module http_request_target_checker
	import htc_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	output logic           full,
	input  wire in_item_t  item,
	input  wire            pop,
	output logic           empty,
	output out_item_t      result
);

	entry_t front_entry;
	entry_t q_entry;
	logic   q_valid;
	logic   q_pop;

	htc_front u_front (
		.item  (item),
		.entry (front_entry)
	);

	htc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_entry),
		.q_full  (full),
		.rd_en   (q_pop),
		.q_valid (q_valid),
		.rd_data (q_entry)
	);

	htc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

`default_nettype wire

// File: rtl/core/htc_checker.sv
// htc_checker: port-level assertions for http_request_target_checker, bound to the top.
// Depends on htc_pkg.
`default_nettype none

module htc_checker
	import htc_pkg::*;
(
	input wire            clk,
	input wire            arst_n,
	input wire            push,
	input wire            full,
	input wire in_item_t  item,
	input wire            pop,
	input wire            empty,
	input wire out_item_t result
);

	// last items accepted minus results taken
	logic [3:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(push && !full && item.last) - 4'(pop && !empty);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed before pop");

	a_form: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.url_form == FORM_PATH || result.url_form == FORM_ABSOLUTE ||
			result.url_form == FORM_AUTHORITY))
		else $error("result carries an unknown form code");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != 4'd0)
		else $error("result shown without an accepted last item");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(QDEPTH + 1))
		else $error("more targets outstanding than the queue and result register hold");

endmodule

bind http_request_target_checker htc_checker u_htc_checker (.*);

`default_nettype wire

// File: bench/http_request_target_checker_tb.sv
// Testbench for http_request_target_checker: request targets go in one byte per transaction.
// Verdicts: local predictor, or a typed row's own; random targets follow the directed table.
// Depends on htc_pkg and the http_request_target_checker RTL.

module http_request_target_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import htc_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic [2:0] {
		TGT_START, TGT_PATHQ, TGT_SCHEME, TGT_COLON, TGT_SLASH, TGT_HOST
	} tgt_phase_t;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_pattern_t;

	typedef struct {
		in_item_t  it;
		logic      typed;
		out_item_t want;
	} tgt_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      pop = 1'b0;
	logic      empty;
	out_item_t result;

	tgt_phase_t tgt_phase;
	logic       tgt_prev_at;
	logic [1:0] tgt_form;
	logic       tgt_failed;

	tgt_row_t    stim_rows[$];
	out_item_t   verdict_q[$];
	int          mismatches = 0;
	int          cycles = 0;
	int          gen_noise;
	logic [5:0]  rx_cnt = '0;
	rx_pattern_t rx_mode = RX_FREE;
	out_item_t   want;

	http_request_target_checker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------- target predictor ----------------

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic pq_ok(input logic [7:0] c);
		return c == 8'd9 || c == 8'd12 || (c >= 8'd33 && c <= 8'd126);
	endfunction

	function automatic logic scheme_ok(input logic [7:0] c);
		return is_letter(c) || is_num(c) || c == "+" || c == "-" || c == ".";
	endfunction

	function automatic logic host_ok(input logic [7:0] c);
		if (is_letter(c) || is_num(c))
			return 1'b1;
		case (c)
			"!", "$", "%", "&", "'", "(", ")", "*", "+", ",", "-", ".", ":", ";",
			"=", "@", "[", "]", "_", "~": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic void clear_target();
		tgt_phase   = TGT_START;
		tgt_prev_at = 1'b0;
		tgt_form    = FORM_PATH;
		tgt_failed  = 1'b0;
	endfunction

	function automatic void host_advance(input logic [7:0] c);
		if (c == "/" || c == "?") begin
			tgt_phase   = TGT_PATHQ;
			tgt_prev_at = 1'b0;
		end else if (!host_ok(c) || (c == "@" && tgt_prev_at)) begin
			tgt_failed = 1'b1;
		end else begin
			tgt_prev_at = (c == "@");
		end
	endfunction

	function automatic void take_byte(input logic [7:0] c, input logic conn);
		case (tgt_phase)
			TGT_START: begin
				if (c == "/" || c == "*") begin
					tgt_form  = FORM_PATH;
					tgt_phase = TGT_PATHQ;
				end else if (conn) begin
					tgt_form  = FORM_AUTHORITY;
					tgt_phase = TGT_HOST;
					host_advance(c);
				end else begin
					tgt_form  = FORM_ABSOLUTE;
					tgt_phase = TGT_SCHEME;
					if (!is_letter(c))
						tgt_failed = 1'b1;
				end
			end
			TGT_PATHQ: begin
				if (!pq_ok(c))
					tgt_failed = 1'b1;
			end
			TGT_SCHEME: begin
				if (c == ":")
					tgt_phase = TGT_COLON;
				else if (!scheme_ok(c))
					tgt_failed = 1'b1;
			end
			TGT_COLON: begin
				if (c == "/")
					tgt_phase = TGT_SLASH;
				else
					tgt_failed = 1'b1;
			end
			TGT_SLASH: begin
				if (c == "/") begin
					tgt_phase   = TGT_HOST;
					tgt_prev_at = 1'b0;
				end else begin
					tgt_failed = 1'b1;
				end
			end
			TGT_HOST: host_advance(c);
			default: tgt_failed = 1'b1;
		endcase
	endfunction

	// returns 1 when the transaction closes a target and yields a verdict
	function automatic logic target_step(input in_item_t it, output out_item_t verdict);
		verdict = '0;
		if (!it.no_byte && !tgt_failed)
			take_byte(it.url_byte, it.connect_mode);
		if (!it.last)
			return 1'b0;
		verdict.url_ok   = !tgt_failed && (tgt_phase == TGT_PATHQ || tgt_phase == TGT_HOST);
		verdict.url_form = tgt_form;
		clear_target();
		return 1'b1;
	endfunction

	// ---------------- stimulus ----------------

	function automatic void add_item(input logic [7:0] c, input logic nb, input logic conn,
			input logic last, input logic typed, input logic ok, input logic [1:0] form);
		tgt_row_t r;
		r.it.url_byte     = c;
		r.it.no_byte      = nb;
		r.it.connect_mode = conn;
		r.it.last         = last;
		r.typed           = typed;
		r.want.url_ok     = ok;
		r.want.url_form   = form;
		stim_rows.push_back(r);
	endfunction

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic logic [7:0] pq_pick();
		case ($urandom_range(19))
			0: return 8'd9;
			1: return 8'd12;
			default: return 8'($urandom_range(33, 126));
		endcase
	endfunction

	function automatic logic [7:0] host_pick();
		if ($urandom_range(4) == 0)
			return "@";
		return pick({"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ",
			"0123456789!$%&'()*+,-.:;=@[]_~"});
	endfunction

	function automatic void emit_byte(input logic [7:0] c, input logic conn, input logic last);
		logic [7:0] b;
		b = c;
		if ($urandom_range(11) == 0)
			add_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)), 1'b0, 1'b0, 1'b0,
				FORM_PATH);
		if (gen_noise != 0 && $urandom_range(gen_noise - 1) == 0)
			b = 8'($urandom_range(255));
		add_item(b, 1'b0, conn, last, 1'b0, 1'b0, FORM_PATH);
	endfunction

	function automatic void build_target();
		logic [7:0] bytes_q[$];
		logic       conn;
		logic       trail_nb;
		int         kind;
		int         n;
		kind      = $urandom_range(9);
		conn      = 1'b0;
		gen_noise = ($urandom_range(3) == 0) ? $urandom_range(2, 10) : 0;
		case (kind)
			1, 2, 3: begin
				bytes_q.push_back(pick("/*"));
				n = $urandom_range(6);
				repeat (n) bytes_q.push_back(pq_pick());
			end
			4, 5, 6: begin
				bytes_q.push_back(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
				n = $urandom_range(4);
				repeat (n) bytes_q.push_back(pick("abcxyzABCXYZ0189+-."));
				bytes_q.push_back(":");
				bytes_q.push_back("/");
				bytes_q.push_back("/");
				n = $urandom_range(6);
				repeat (n) bytes_q.push_back(host_pick());
				if ($urandom_range(1)) begin
					bytes_q.push_back(pick("/?"));
					n = $urandom_range(4);
					repeat (n) bytes_q.push_back(pq_pick());
				end
			end
			7, 8: begin
				conn = 1'b1;
				n = $urandom_range(1, 6);
				repeat (n) bytes_q.push_back(host_pick());
				if ($urandom_range(1)) begin
					bytes_q.push_back(pick("/?"));
					n = $urandom_range(4);
					repeat (n) bytes_q.push_back(pq_pick());
				end
			end
			9: begin
				conn = 1'($urandom_range(1));
				n = $urandom_range(1, 6);
				repeat (n) bytes_q.push_back(8'($urandom_range(255)));
			end
			default: ;
		endcase
		trail_nb = (bytes_q.size() == 0) || ($urandom_range(5) == 0);
		foreach (bytes_q[i])
			emit_byte(bytes_q[i], (i == 0) ? conn : 1'($urandom_range(1)),
				(i == bytes_q.size() - 1) && !trail_nb);
		if (trail_nb)
			add_item(8'($urandom_range(255)), 1'b1, 1'($urandom_range(1)), 1'b1, 1'b0, 1'b0,
				FORM_PATH);
	endfunction

	function automatic void load_directed();
		// byte      nb    conn  last  typed ok    form
		add_item(8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, FORM_PATH);       // empty target
		add_item("/",   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, FORM_PATH);
		add_item("*",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item(8'h7E, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, FORM_PATH);
		add_item("/",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, FORM_PATH);
		add_item(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, FORM_ABSOLUTE);   // high byte, no letter
		add_item("a",   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, FORM_PATH);       // double at sign
		add_item("@",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item("@",   1'b0, 1'b1, 1'b1, 1'b1, 1'b0, FORM_AUTHORITY);
		add_item("h",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);       // ends inside "://"
		add_item(":",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item("/",   1'b0, 1'b0, 1'b1, 1'b1, 1'b0, FORM_ABSOLUTE);
		add_item("h",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);       // empty host
		add_item(":",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item("/",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item("/",   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, FORM_ABSOLUTE);
		add_item("?",   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, FORM_PATH);       // byteless last
		add_item(8'h55, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, FORM_PATH);
		add_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);       // bytes after failure
		add_item("/",   1'b0, 1'b1, 1'b1, 1'b0, 1'b0, FORM_PATH);
		add_item("/",   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item(8'h09, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item(8'h0C, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, FORM_PATH);
		add_item(8'h80, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, FORM_PATH);
	endfunction

	// ---------------- sender ----------------

	initial begin
		tgt_row_t  cur;
		out_item_t pred;
		int        burst_left;
		int        total;
		push   = 1'b0;
		item   = '0;
		arst_n = 1'b0;
		clear_target();
		load_directed();
		total = stim_rows.size() + RANDOM_ITEMS;
		while (stim_rows.size() < total)
			build_target();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		burst_left = 0;
		while (stim_rows.size() != 0) begin
			if (burst_left == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 16);
			end
			cur = stim_rows.pop_front();
			push <= 1'b1;
			item <= cur.it;
			@(posedge clk);
			while (full)
				@(posedge clk);
			if (target_step(cur.it, pred))
				verdict_q.push_back(cur.typed ? cur.want : pred);
			burst_left--;
			@(negedge clk);
		end
		push <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ---------------- receiver ----------------

	always @(negedge clk) begin
		rx_cnt <= rx_cnt + 6'd1;
		if (rx_cnt == 6'd0)
			rx_mode <= rx_pattern_t'($urandom_range(3));
		case (rx_mode)
			RX_FREE:   pop <= 1'b1;
			RX_COIN:   pop <= 1'($urandom_range(1));
			RX_SPARSE: pop <= ($urandom_range(3) == 0);
			default:   pop <= (rx_cnt[4:3] != 2'd0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: url_ok=%0d url_form=%0d",
						result.url_ok, result.url_form);
			end else begin
				want = verdict_q.pop_front();
				if (result.url_ok !== want.url_ok || result.url_form !== want.url_form) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want ok=%0d form=%0d, got ok=%0d form=%0d",
							want.url_ok, want.url_form, result.url_ok, result.url_form);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

// File: filelist.f
rtl/core/htc_pkg.sv
rtl/core/htc_front.sv
rtl/core/htc_queue.sv
rtl/core/htc_back.sv
rtl/core/http_request_target_checker.sv
rtl/core/htc_checker.sv
bench/http_request_target_checker_tb.sv
